// ----- rtl/ufd_pkg.sv -----
`timescale 1ns / 1ps
// Package of types, codes and helpers shared by the form field decoder.
package ufd_pkg;

    localparam int unsigned CH_W        = 8;
    localparam int unsigned KIND_W      = 2;
    localparam int unsigned NAME_LIM_W  = 8;
    localparam int unsigned VALUE_LIM_W = 10;
    localparam int unsigned CFG_DATA_W  = 10;
    localparam int unsigned CFG_IDX_W   = 1;

    typedef logic [CH_W-1:0]        t_byte;
    typedef logic [KIND_W-1:0]      t_kind;
    typedef logic [NAME_LIM_W-1:0]  t_name_cnt;
    typedef logic [VALUE_LIM_W-1:0] t_value_cnt;
    typedef logic [CFG_IDX_W-1:0]   t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0]  t_cfg_data;
    typedef logic [1:0]             t_esc;

    localparam t_byte CH_NUL     = 8'h00;
    localparam t_byte CH_EQUALS  = 8'h3D;
    localparam t_byte CH_AMP     = 8'h26;
    localparam t_byte CH_PERCENT = 8'h25;

    localparam t_kind KIND_NAME  = 2'd0;
    localparam t_kind KIND_VALUE = 2'd1;
    localparam t_kind KIND_END   = 2'd2;

    localparam t_esc ESC_IDLE  = 2'd0;
    localparam t_esc ESC_PCT   = 2'd1;
    localparam t_esc ESC_DIGIT = 2'd2;
    localparam t_esc ESC_UNUSED = 2'd3;

    localparam t_cfg_idx CFG_NAME_LIMIT  = 1'b0;
    localparam t_cfg_idx CFG_VALUE_LIMIT = 1'b1;

    localparam t_name_cnt  NAME_LIMIT_RST  = 8'd32;
    localparam t_value_cnt VALUE_LIMIT_RST = 10'd256;

    typedef struct packed {
        logic  is_hex;
        logic [3:0] digit;
    } t_hex;

    typedef struct packed {
        t_kind kind;
        t_byte data;
        logic  keep;
        logic  done_res;
    } t_result;

    function automatic t_hex hex_val(input t_byte b);
        t_hex h;
        h.is_hex = 1'b0;
        h.digit  = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            h.is_hex = 1'b1;
            h.digit  = b[3:0];
        end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
            h.is_hex = 1'b1;
            h.digit  = b[3:0] + 4'd9;
        end
        return h;
    endfunction

endpackage

// ----- rtl/ufd_byte_if.sv -----
`timescale 1ns / 1ps
// Handshake channel carrying one input byte per beat.
interface ufd_byte_if;
    logic               valid;
    logic               ready;
    ufd_pkg::t_byte     ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

// ----- rtl/ufd_res_if.sv -----
`timescale 1ns / 1ps
// Handshake channel carrying one decoded result per beat.
interface ufd_res_if;
    logic               valid;
    logic               ready;
    ufd_pkg::t_kind     kind;
    ufd_pkg::t_byte     data;
    logic               keep;
    logic               done_res;

    modport source (output valid, output kind, output data, output keep, output done_res,
                    input ready);
    modport sink   (input valid, input kind, input data, input keep, input done_res,
                    output ready);
endinterface

// ----- rtl/ufd_in_stage.sv -----
`timescale 1ns / 1ps
// Input register stage that holds one accepted byte until the decoder takes it.
module ufd_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ufd_byte_if.sink       i_in,
    input  logic           i_advance,
    output logic           o_vld,
    output ufd_pkg::t_byte o_ch
);
    import ufd_pkg::*;

    logic  r_vld;
    t_byte r_ch;

    assign i_in.ready = !r_vld || i_advance;
    assign o_vld      = r_vld;
    assign o_ch       = r_ch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_ch <= i_in.ch;
        end
    end
endmodule

// ----- rtl/ufd_core.sv -----
`timescale 1ns / 1ps
// Field state, percent decoding and the result register of the decoder.
module ufd_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  ufd_pkg::t_cfg_idx   i_cfg_idx,
    input  ufd_pkg::t_cfg_data  i_cfg_data,
    input  logic                i_vld,
    input  ufd_pkg::t_byte      i_ch,
    output logic                o_advance,
    ufd_res_if.source           o_res
);
    import ufd_pkg::*;

    t_name_cnt  r_name_limit;
    t_value_cnt r_value_limit;

    logic       r_in_value,  n_in_value;
    t_esc       r_esc,       n_esc;
    logic [3:0] r_first,     n_first;
    t_name_cnt  r_name_cnt,  n_name_cnt;
    t_value_cnt r_value_cnt, n_value_cnt;
    logic       r_cut,       n_cut;

    logic       r_out_vld;
    t_result    r_out;
    t_result    n_out;
    logic       n_produce;

    t_hex       hex;
    logic       emit;
    t_byte      emit_byte;

    assign o_advance = i_vld && (!r_out_vld || o_res.ready);

    always_comb begin
        hex         = hex_val(i_ch);
        n_in_value  = r_in_value;
        n_esc       = r_esc;
        n_first     = r_first;
        n_name_cnt  = r_name_cnt;
        n_value_cnt = r_value_cnt;
        n_cut       = r_cut;
        n_produce   = 1'b0;
        n_out       = '0;
        emit        = 1'b0;
        emit_byte   = i_ch;
        if (i_ch == CH_NUL || i_ch == CH_AMP) begin
            n_in_value     = 1'b0;
            n_esc          = ESC_IDLE;
            n_first        = 4'd0;
            n_name_cnt     = '0;
            n_value_cnt    = '0;
            n_cut          = 1'b0;
            n_produce      = 1'b1;
            n_out.kind     = KIND_END;
            n_out.keep     = (i_ch == CH_AMP) || (r_name_cnt != '0);
            n_out.done_res = (i_ch == CH_NUL);
        end else if (!r_in_value) begin
            if (i_ch == CH_EQUALS) begin
                n_in_value = 1'b1;
            end else if (r_name_cnt < r_name_limit) begin
                n_name_cnt = r_name_cnt + 1'b1;
                n_produce  = 1'b1;
                n_out.kind = KIND_NAME;
                n_out.data = i_ch;
            end
        end else if (r_value_cnt < r_value_limit) begin
            n_value_cnt = r_value_cnt + 1'b1;
            unique case (r_esc)
                ESC_PCT: begin
                    if (i_ch != CH_PERCENT && hex.is_hex) begin
                        n_first = hex.digit;
                        n_esc   = ESC_DIGIT;
                    end else begin
                        n_esc = ESC_IDLE;
                        emit  = 1'b1;
                    end
                end
                ESC_DIGIT: begin
                    n_esc = ESC_IDLE;
                    emit  = 1'b1;
                    if (hex.is_hex) begin
                        emit_byte = {r_first, hex.digit};
                    end
                end
                ESC_IDLE, ESC_UNUSED: begin
                    if (i_ch == CH_PERCENT) begin
                        n_esc = ESC_PCT;
                    end else begin
                        n_esc = ESC_IDLE;
                        emit  = 1'b1;
                    end
                end
                default: begin
                    n_esc = ESC_IDLE;
                end
            endcase
            if (emit && !r_cut) begin
                if (emit_byte == CH_NUL) begin
                    n_cut = 1'b1;
                end else begin
                    n_produce  = 1'b1;
                    n_out.kind = KIND_VALUE;
                    n_out.data = emit_byte;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name_limit  <= NAME_LIMIT_RST;
            r_value_limit <= VALUE_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_NAME_LIMIT:  r_name_limit  <= i_cfg_data[NAME_LIM_W-1:0];
                CFG_VALUE_LIMIT: r_value_limit <= i_cfg_data[VALUE_LIM_W-1:0];
                default:         r_name_limit  <= r_name_limit;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_value  <= 1'b0;
            r_esc       <= ESC_IDLE;
            r_first     <= 4'd0;
            r_name_cnt  <= '0;
            r_value_cnt <= '0;
            r_cut       <= 1'b0;
            r_out_vld   <= 1'b0;
        end else if (o_advance) begin
            r_in_value  <= n_in_value;
            r_esc       <= n_esc;
            r_first     <= n_first;
            r_name_cnt  <= n_name_cnt;
            r_value_cnt <= n_value_cnt;
            r_cut       <= n_cut;
            r_out_vld   <= n_produce;
        end else if (o_res.ready) begin
            r_out_vld   <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && n_produce) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid    = r_out_vld;
    assign o_res.kind     = r_out.kind;
    assign o_res.data     = r_out.data;
    assign o_res.keep     = r_out.keep;
    assign o_res.done_res = r_out.done_res;

    a_esc_reachable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_esc != ESC_UNUSED)
        else $error("escape phase reached an unused code");

    a_esc_in_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_esc != ESC_IDLE) |-> r_in_value)
        else $error("escape pending outside a value");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_advance && n_produce && n_out.kind == KIND_END)
        |=> (!r_in_value && r_name_cnt == '0 && r_value_cnt == '0 && !r_cut))
        else $error("field state not cleared after a field end");

    a_flags_only_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.kind != KIND_END) |-> (!r_out.keep && !r_out.done_res))
        else $error("keep or done flag set on a data beat");

    a_value_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.kind == KIND_VALUE) |-> (r_out.data != CH_NUL))
        else $error("zero byte emitted as a value byte");
endmodule

// ----- rtl/url_form_field_decoder.sv -----
`timescale 1ns / 1ps
// Top level of the URL form field decoder.
//
// Bytes of a form-encoded string arrive on i_in, one per beat; a zero byte ends
// the string. Each byte yields at most one beat on o_res: a name byte, a
// percent-decoded value byte or a field end, which '&' and the end of the string
// both cause. Name and raw value lengths are capped by two registers written
// through the i_cfg_* port (index 0 name limit, 1 value limit); the user must
// write them only while the block is idle, which the block does not enforce.
// A byte accepted into the input register is decoded into the result register,
// where any result it yields is shown on o_res; one byte is taken every cycle when o_res is ready.
// A byte is still accepted into the input register while a result waits, but it
// moves on to the decoder only once the result register is free, even when it
// yields no result. When o_res stalls with a result held, at most one further
// byte is held in the input register and i_in.ready drops.
// Reset clears both registers' valid flags and the field state and restores
// the limits to 32 and 256.
module url_form_field_decoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  ufd_pkg::t_cfg_idx  i_cfg_idx,
    input  ufd_pkg::t_cfg_data i_cfg_data,
    ufd_byte_if.sink           i_in,
    ufd_res_if.source          o_res
);
    import ufd_pkg::*;

    logic  stage_vld;
    t_byte stage_ch;
    logic  advance;

    ufd_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_advance (advance),
        .o_vld     (stage_vld),
        .o_ch      (stage_ch)
    );

    ufd_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_vld      (stage_vld),
        .i_ch       (stage_ch),
        .o_advance  (advance),
        .o_res      (o_res)
    );
endmodule
